// File: hw/rtl/plt_pkg.sv
// Shared types and codes for the positional list store.
package plt_pkg;

  localparam int DATA_W   = 32;
  localparam int POS_W    = 6;
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 3;

  localparam logic [KIND_W-1:0] KIND_INS_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INS_END   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_INS_POS   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DELETE    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DISPLAY   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_SEARCH    = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

  typedef enum logic [1:0] {
    CM_HOLD,
    CM_INSERT,
    CM_DELETE,
    CM_ROTATE
  } cell_mode_t;

  // Broadcast to every cell of the chain
  typedef struct packed {
    cell_mode_t        mode;
    logic [DATA_W-1:0] data;
  } cell_cmd_t;

endpackage

// File: hw/rtl/positional_list_store.sv
// Positional list store: ordered list of signed words held in a chain of shifting cells.
// Insert and delete: result in the cycle after start; kinds 6 and 7 give no result.
// Search: compare in all cells, register the hits, then a registered priority pick; busy during the pick.
// Display: one element per cycle from the head of a rotating chain; busy until every element is shown.
// Results carry a one-cycle valid strobe; the receiver cannot stall.
// Synchronous reset empties the list; stored words are not cleared.
module positional_list_store #(
  parameter int CAPACITY = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [plt_pkg::KIND_W-1:0]        kind,
  input  logic [plt_pkg::POS_W-1:0]         position,
  input  logic signed [plt_pkg::DATA_W-1:0] value,
  output logic                              valid,
  output logic [plt_pkg::STATUS_W-1:0]      status,
  output logic signed [plt_pkg::DATA_W-1:0] element,
  output logic [plt_pkg::POS_W-1:0]         found_position,
  output logic                              last
);
  import plt_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OCC_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((OCC_W > POS_W) ? OCC_W : POS_W) + 1;
  localparam logic [OCC_W-1:0] CAP_OCC = OCC_W'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DISP = 3'b010,
    S_SRCH = 3'b100
  } state_t;

  state_t            state, state_next;
  logic [OCC_W-1:0]  occ, occ_next;
  logic [OCC_W-1:0]  cnt, cnt_next;
  logic [CAPACITY-1:0] hits, hits_next;

  logic                valid_next;
  logic [STATUS_W-1:0] status_next;
  logic [DATA_W-1:0]   element_next;
  logic [POS_W-1:0]    found_position_next;
  logic                last_next;

  cell_cmd_t          cmd;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   last_idx;
  logic [DATA_W-1:0]  vals [CAPACITY];
  logic [CAPACITY-1:0] hit;

  logic             accept;
  logic             full;
  logic             empty;
  logic [CMP_W-1:0] pos_x;
  logic [CMP_W-1:0] occ_x;
  logic [OCC_W-1:0] occ_m1;
  logic [OCC_W-1:0] cnt_inc;
  logic [CMP_W-1:0] pos_m1;
  logic [IDX_W-1:0] first_idx;
  logic             any_hit;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign full    = (occ == CAP_OCC);
  assign empty   = (occ == '0);
  assign pos_x   = CMP_W'(position);
  assign occ_x   = CMP_W'(occ);
  assign pos_m1  = pos_x - CMP_W'(1);
  assign occ_m1  = occ - OCC_W'(1);
  assign cnt_inc = cnt + OCC_W'(1);

  // chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_v;
    logic [DATA_W-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid
      assign left_v = vals[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_v = vals[i];
    end else begin : g_inner
      assign right_v = vals[i+1];
    end
    plt_cell #(
      .IDX_W (IDX_W),
      .INDEX (i)
    ) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .idx      (idx),
      .last_idx (last_idx),
      .left     (left_v),
      .right    (right_v),
      .head     (vals[0]),
      .value    (vals[i]),
      .hit      (hit[i])
    );
  end

  // frontmost match among registered hits
  always_comb begin
    first_idx = '0;
    any_hit   = 1'b0;
    for (int j = CAPACITY - 1; j >= 0; j--) begin
      if (hits[j]) begin
        first_idx = IDX_W'(j);
        any_hit   = 1'b1;
      end
    end
  end

  always_comb begin
    state_next          = state;
    occ_next            = occ;
    cnt_next            = cnt;
    hits_next           = hits;
    cmd.mode            = CM_HOLD;
    cmd.data            = value;
    idx                 = '0;
    last_idx            = occ_m1[IDX_W-1:0];
    valid_next          = 1'b0;
    status_next         = ST_OK;
    element_next        = '0;
    found_position_next = '0;
    last_next           = 1'b1;

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (kind)
            KIND_INS_FRONT, KIND_INS_END: begin
              valid_next = 1'b1;
              if (full) begin
                status_next = ST_FULL;
              end else begin
                cmd.mode = CM_INSERT;
                idx      = (kind == KIND_INS_FRONT) ? '0 : occ[IDX_W-1:0];
                occ_next = occ + OCC_W'(1);
              end
            end
            KIND_INS_POS: begin
              valid_next = 1'b1;
              if (pos_x == '0 || pos_x > occ_x + CMP_W'(1)) begin
                status_next = ST_RANGE;
              end else if (full) begin
                status_next = ST_FULL;
              end else begin
                cmd.mode = CM_INSERT;
                idx      = pos_m1[IDX_W-1:0];
                occ_next = occ + OCC_W'(1);
              end
            end
            KIND_DELETE: begin
              valid_next = 1'b1;
              if (empty) begin
                status_next = ST_EMPTY;
              end else if (pos_x == '0 || pos_x > occ_x) begin
                status_next = ST_RANGE;
              end else begin
                cmd.mode = CM_DELETE;
                idx      = pos_m1[IDX_W-1:0];
                occ_next = occ_m1;
              end
            end
            KIND_DISPLAY: begin
              if (empty) begin
                valid_next  = 1'b1;
                status_next = ST_EMPTY;
              end else begin
                cnt_next   = '0;
                state_next = S_DISP;
              end
            end
            KIND_SEARCH: begin
              if (empty) begin
                valid_next  = 1'b1;
                status_next = ST_EMPTY;
              end else begin
                // only occupied cells may match
                for (int j = 0; j < CAPACITY; j++) begin
                  hits_next[j] = hit[j] && (OCC_W'(j) < occ);
                end
                state_next = S_SRCH;
              end
            end
            default: begin
              valid_next = 1'b0;
            end
          endcase
        end
      end
      S_DISP: begin
        cmd.mode            = CM_ROTATE;
        valid_next          = 1'b1;
        element_next        = vals[0];
        found_position_next = POS_W'(cnt_inc);
        last_next           = (cnt_inc == occ);
        cnt_next            = cnt_inc;
        if (cnt_inc == occ) begin
          state_next = S_IDLE;
        end
      end
      S_SRCH: begin
        valid_next = 1'b1;
        if (any_hit) begin
          found_position_next = POS_W'(first_idx) + POS_W'(1);
        end else begin
          status_next = ST_NOTFOUND;
        end
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      occ   <= '0;
      cnt   <= '0;
      valid <= 1'b0;
    end else begin
      state <= state_next;
      occ   <= occ_next;
      cnt   <= cnt_next;
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    hits           <= hits_next;
    status         <= status_next;
    element        <= element_next;
    found_position <= found_position_next;
    last           <= last_next;
  end

endmodule

// File: hw/rtl/plt_cell.sv
// One storage cell of the list chain: holds one element, shifts with its neighbours.
module plt_cell #(
  parameter int IDX_W = 5,
  parameter int INDEX = 0
) (
  input  logic                     clk,
  input  plt_pkg::cell_cmd_t       cmd,
  input  logic [IDX_W-1:0]         idx,
  input  logic [IDX_W-1:0]         last_idx,
  input  logic [plt_pkg::DATA_W-1:0] left,
  input  logic [plt_pkg::DATA_W-1:0] right,
  input  logic [plt_pkg::DATA_W-1:0] head,
  output logic [plt_pkg::DATA_W-1:0] value,
  output logic                     hit
);
  import plt_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [DATA_W-1:0] value_next;

  always_comb begin
    value_next = value;
    case (cmd.mode)
      CM_INSERT: begin
        if (MY_IDX == idx) begin
          value_next = cmd.data;
        end else if (MY_IDX > idx) begin
          value_next = left;
        end
      end
      CM_DELETE: begin
        if (MY_IDX >= idx) begin
          value_next = right;
        end
      end
      // wrap the front element round to the last occupied cell
      CM_ROTATE: begin
        value_next = (MY_IDX == last_idx) ? head : right;
      end
      default: value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

  assign hit = (value == cmd.data);

endmodule
